@@ hw/rtl/heart_rate_from_peaks_defines.svh @@
// assertion macros for the heart rate blocks, used by the rate engine
`ifndef HEART_RATE_FROM_PEAKS_DEFINES_SVH
`define HEART_RATE_FROM_PEAKS_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define HRP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hrp_pkg.sv @@
// shared types and constants of the heart rate block
`default_nettype none

package hrp_pkg;

  localparam int unsigned AVG_DEPTH_DEF   = 5;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  localparam int unsigned THR_W      = 12;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned RATE_W     = 9;
  localparam int unsigned DIVD_W     = 16;
  localparam int unsigned QUOT_W     = 9;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_THRESHOLD  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM_MARGIN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL_MS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL_MS = 8'd3;

  localparam logic [THR_W-1:0]      BEAT_THRESHOLD_RST  = 12'd2500;
  localparam logic [THR_W-1:0]      REARM_MARGIN_RST    = 12'd200;
  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST    = 16'd300;
  localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RST    = 16'd2000;

  localparam logic [DIVD_W-1:0]     RATE_NUMERATOR    = 16'd60000;
  localparam logic [RATE_W-1:0]     RATE_MAX          = 9'd300;
  // at or below this interval the rate saturates
  localparam logic [INTERVAL_W-1:0] RATE_SAT_INTERVAL = 16'd200;

  typedef enum logic [1:0] {
    CMD_REPORT,
    CMD_LEADOFF,
    CMD_PUSH
  } hrp_cmd_e;

  typedef struct packed {
    hrp_cmd_e                kind;
    logic [INTERVAL_W-1:0]   interval;
  } hrp_cmd_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } hrp_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } hrp_div_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/hrp_if.sv @@
// channel interfaces: sample words in, rate words out, register writes
`default_nettype none

interface hrp_in_if import hrp_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TIME_W-1:0]      now_ms;
  logic                   lead_off_plus;
  logic                   lead_off_minus;

  modport source (output valid, sample, now_ms, lead_off_plus, lead_off_minus, input ready);
  modport sink   (input valid, sample, now_ms, lead_off_plus, lead_off_minus, output ready);
endinterface

interface hrp_out_if import hrp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] bpm;
  logic              leads_on;

  modport source (output valid, bpm, leads_on, input ready);
  modport sink   (input valid, bpm, leads_on, output ready);
endinterface

interface hrp_cfg_if import hrp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/heart_rate_from_peaks.sv @@
// top level of the R-peak heart rate block
`default_nettype none

// heart_rate_from_peaks takes one ECG word per handshake (sample, millisecond
// timestamp, two lead-off flags) and returns exactly one rate word for it
// (bpm, leads_on), in order. the front end takes a word in the cycle it is
// offered as long as the two-entry command queue has room; it applies the
// lead-off check, the threshold/hysteresis beat detector and the interval
// range test at once, so back-to-back words enter without waiting. the rate
// engine drains the queue: a word that brings no new accepted beat goes from
// the queue pop straight to the result register. a word with an accepted beat
// runs the shared restoring divider for 60000/interval (skipped when the
// interval is 200 ms or less, which saturates at 300 bpm), writes the history
// ring, sums the valid entries over the single ring read port, a read and an
// add state per entry, then divides by the entry count on the same divider.
// registers are to be written over the cfg channel (index 0 threshold,
// 1 re-arm margin, 2 min and 3 max interval in ms, other indexes ignored)
// only while no word is in flight; the block itself does not enforce this
module heart_rate_from_peaks import hrp_pkg::*; #(
  parameter int unsigned AVG_DEPTH   = AVG_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hrp_cfg_if.sink   cfg_i,
  hrp_in_if.sink    in_i,
  hrp_out_if.source out_o
);

  // queue handshake between the two halves
  logic     q_push, q_full, q_pop, q_empty;
  hrp_cmd_t q_wdata, q_head;

  // classifier and register file
  hrp_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_wdata)
  );

  // decouples word intake from the slow rate path
  hrp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // rate arithmetic, history ring and result register
  hrp_back #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/hrp_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none

module hrp_div import hrp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  hrp_div_req_t req_i,
  output hrp_div_rsp_t rsp_o
);

  localparam int unsigned DSH_W = DIVD_W + QUOT_W - 1;
  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVD_W-1:0] rem_q;
  logic [DSH_W-1:0]  dsh_q;
  logic [QUOT_W-1:0] quo_q;
  logic              ge;
  logic              start;

  assign start = req_i.start && !busy_q;
  assign ge    = {{(QUOT_W-1){1'b0}}, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUOT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  // datapath, caller keeps dividend below divisor shifted by the quotient width
  always_ff @(posedge clk_i) begin
    if (start) begin
      rem_q <= req_i.dividend;
      dsh_q <= {req_i.divisor, {(QUOT_W-1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q[DIVD_W-1:0];
      end
      quo_q <= {quo_q[QUOT_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

@@ hw/rtl/hrp_fifo.sv @@
// short command queue between the classifier and the rate engine
`default_nettype none

module hrp_fifo import hrp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hrp_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output hrp_cmd_t head_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  hrp_cmd_t         entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rptr_q];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= ptr_inc(wptr_q);
      if (do_pop)  rptr_q <= ptr_inc(rptr_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

@@ hw/rtl/hrp_front.sv @@
// front end: register file, lead-off check, beat detector, interval measure
`default_nettype none

module hrp_front import hrp_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  hrp_cfg_if.sink  cfg_i,
  hrp_in_if.sink   in_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output hrp_cmd_t q_cmd_o
);

  localparam int unsigned CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic [THR_W-1:0]      thr_q, margin_q;
  logic [INTERVAL_W-1:0] min_q, max_q;
  logic                  armed_q;
  logic [TIME_W-1:0]     last_q;

  logic [CMP_W-1:0]  smp, thr, rearm_lvl;
  logic [TIME_W-1:0] diff;
  logic              lead_off, beat, rearm, in_range, accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_full_i;
  assign accept      = in_i.valid && !q_full_i;

  assign smp       = CMP_W'(in_i.sample[SAMPLE_BITS-1:0]);
  assign thr       = CMP_W'(thr_q);
  assign rearm_lvl = CMP_W'(thr_q - margin_q);
  assign lead_off  = in_i.lead_off_plus || in_i.lead_off_minus;
  assign beat      = (smp > thr) && !armed_q;
  assign rearm     = (margin_q <= thr_q) && (smp < rearm_lvl);

  assign diff     = in_i.now_ms - last_q;
  assign in_range = (diff >= TIME_W'(min_q)) && (diff <= TIME_W'(max_q));

  always_comb begin
    q_cmd_o.kind     = CMD_REPORT;
    q_cmd_o.interval = diff[INTERVAL_W-1:0];
    if (lead_off) begin
      q_cmd_o.kind = CMD_LEADOFF;
    end else if (beat && (last_q != '0) && in_range) begin
      q_cmd_o.kind = CMD_PUSH;
    end
  end
  assign q_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= BEAT_THRESHOLD_RST;
      margin_q <= REARM_MARGIN_RST;
      min_q    <= MIN_INTERVAL_RST;
      max_q    <= MAX_INTERVAL_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BEAT_THRESHOLD:  thr_q    <= cfg_i.data[THR_W-1:0];
        CFG_REARM_MARGIN:    margin_q <= cfg_i.data[THR_W-1:0];
        CFG_MIN_INTERVAL_MS: min_q    <= cfg_i.data[INTERVAL_W-1:0];
        CFG_MAX_INTERVAL_MS: max_q    <= cfg_i.data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      last_q  <= '0;
    end else if (accept) begin
      if (lead_off) begin
        armed_q <= 1'b0;
      end else if (beat) begin
        armed_q <= 1'b1;
        last_q  <= in_i.now_ms;
      end else if (rearm) begin
        armed_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hrp_back.sv @@
// rate engine: interval to rate, history ring, running mean, result register
`default_nettype none
`include "heart_rate_from_peaks_defines.svh"

module hrp_back import hrp_pkg::*; #(
  parameter int unsigned AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  hrp_cmd_t  cmd_i,
  output logic      cmd_pop_o,
  hrp_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(AVG_DEPTH + 1);
  localparam int unsigned IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned SUM_W = RATE_W + CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVR  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_MEAN  = 3'd5;
  localparam logic [2:0] S_DIVM  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]        state_q;
  logic [RATE_W-1:0] rate_q;
  logic [IDX_W-1:0]  slot_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [SUM_W-1:0]  sum_q;
  logic [RATE_W-1:0] new_q, rd_q, bpm_q;
  logic              leads_q;
  logic [RATE_W-1:0] ring_q [AVG_DEPTH];

  hrp_div_req_t div_req;
  hrp_div_rsp_t div_rsp;
  logic         take, need_div;

  hrp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign take      = (state_q == S_IDLE) && cmd_valid_i;
  assign cmd_pop_o = take;
  assign need_div  = cmd_i.interval > RATE_SAT_INTERVAL;
  assign idx_d     = idx_q + CNT_W'(1);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = RATE_NUMERATOR;
    div_req.divisor  = cmd_i.interval;
    if (take && (cmd_i.kind == CMD_PUSH) && need_div) begin
      div_req.start = 1'b1;
    end else if (state_q == S_MEAN) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIVD_W'(sum_q);
      div_req.divisor  = DIVD_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rate_q  <= '0;
      slot_q  <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (take) begin
            case (cmd_i.kind)
              CMD_LEADOFF: begin
                rate_q  <= '0;
                state_q <= S_OUT;
              end
              CMD_PUSH: state_q <= need_div ? S_DIVR : S_WRITE;
              default:  state_q <= S_OUT;
            endcase
          end
        end
        S_DIVR: if (div_rsp.done) state_q <= S_WRITE;
        S_WRITE: begin
          slot_q  <= (slot_q == IDX_W'(AVG_DEPTH - 1)) ? '0 : slot_q + IDX_W'(1);
          if (cnt_q != CNT_W'(AVG_DEPTH)) cnt_q <= cnt_q + CNT_W'(1);
          state_q <= S_READ;
        end
        S_READ: state_q <= S_ADD;
        S_ADD:  state_q <= (idx_d == cnt_q) ? S_MEAN : S_READ;
        S_MEAN: state_q <= S_DIVM;
        S_DIVM: begin
          if (div_rsp.done) begin
            rate_q  <= div_rsp.quotient;
            state_q <= S_OUT;
          end
        end
        S_OUT: if (out_o.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath and history ring
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        new_q   <= RATE_MAX;
        bpm_q   <= (cmd_i.kind == CMD_LEADOFF) ? '0 : rate_q;
        leads_q <= cmd_i.kind != CMD_LEADOFF;
      end
      S_DIVR: if (div_rsp.done) new_q <= div_rsp.quotient;
      S_WRITE: begin
        ring_q[slot_q] <= new_q;
        idx_q <= '0;
        sum_q <= '0;
      end
      S_READ: rd_q <= ring_q[idx_q[IDX_W-1:0]];
      S_ADD: begin
        sum_q <= sum_q + SUM_W'(rd_q);
        idx_q <= idx_d;
      end
      S_DIVM: begin
        bpm_q   <= div_rsp.quotient;
        leads_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_o.valid    = state_q == S_OUT;
  assign out_o.bpm      = bpm_q;
  assign out_o.leads_on = leads_q;

  `HRP_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(AVG_DEPTH), "history count overflow")
  `HRP_ASSERT_IMPL(a_div_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `HRP_ASSERT_IMPL(a_mean_cnt, state_q == S_MEAN, cnt_q != '0, "mean over empty history")
  `HRP_ASSERT_NEXT(a_mean_out, (state_q == S_DIVM) && div_rsp.done, state_q == S_OUT, "mean lost")

endmodule

`default_nettype wire

@@ tb/heart_rate_checker.sv @@
// checker: watches the channels, predicts each rate word and compares it
`timescale 1ns / 100ps

module heart_rate_checker import hrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrp_cfg_if          cfg_i,
  hrp_in_if           word_i,
  hrp_out_if          rate_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned RING_DEPTH = AVG_DEPTH_DEF;
  localparam int unsigned BPM_PER_MS = 60000;
  localparam int unsigned BPM_CEIL   = 300;
  localparam int unsigned SHOW_FAULTS = 10;

  typedef struct packed {
    logic [SAMPLE_BITS_DEF-1:0] sample;
    logic [TIME_W-1:0]          now_ms;
    logic                       lead_off_plus;
    logic                       lead_off_minus;
  } ecg_word_t;

  typedef struct packed {
    logic [RATE_W-1:0] bpm;
    logic              leads_on;
  } rate_word_t;

  // register copies
  logic [THR_W-1:0]      threshold;
  logic [THR_W-1:0]      margin;
  logic [INTERVAL_W-1:0] shortest_ms;
  logic [INTERVAL_W-1:0] longest_ms;

  // detector and averaging state
  logic              armed;
  logic [TIME_W-1:0] last_beat;
  logic [RATE_W-1:0] rate_now;
  logic [RATE_W-1:0] ring [RING_DEPTH];
  int unsigned       slot;
  int unsigned       filled;

  rate_word_t  rate_words_due [$];
  int unsigned fault_count;

  function automatic logic [RATE_W-1:0] rate_of_interval(input logic [TIME_W-1:0] iv);
    logic [TIME_W-1:0] q;
    if (iv == '0) return RATE_W'(BPM_CEIL);
    q = BPM_PER_MS / iv;
    return (q > BPM_CEIL) ? RATE_W'(BPM_CEIL) : q[RATE_W-1:0];
  endfunction

  // one ECG word through the detector, returns the rate word it gives
  function automatic rate_word_t beat_rate_step(input ecg_word_t w);
    rate_word_t        r;
    logic [TIME_W-1:0] iv;
    int unsigned       acc;
    int unsigned       i;
    if (w.lead_off_plus || w.lead_off_minus) begin
      rate_now   = '0;
      armed      = 1'b0;
      r.bpm      = '0;
      r.leads_on = 1'b0;
      return r;
    end
    if (w.sample > threshold && !armed) begin
      armed = 1'b1;
      // a stored time of zero reads as no previous beat
      if (last_beat != '0) begin
        iv = w.now_ms - last_beat;
        if (iv >= shortest_ms && iv <= longest_ms) begin
          ring[slot] = rate_of_interval(iv);
          slot = (slot + 1) % RING_DEPTH;
          if (filled < RING_DEPTH) filled++;
          acc = 0;
          for (i = 0; i < filled; i++) acc += ring[i];
          rate_now = RATE_W'(acc / filled);
        end
      end
      last_beat = w.now_ms;
    end else if (margin <= threshold && w.sample < threshold - margin) begin
      armed = 1'b0;
    end
    r.bpm      = rate_now;
    r.leads_on = 1'b1;
    return r;
  endfunction

  task automatic note_fault(input string what, input rate_word_t due,
                            input logic [RATE_W-1:0] bpm, input logic on);
    if (fault_count < SHOW_FAULTS)
      $display("%0t: %s: expected bpm %0d leads_on %0b, got bpm %0d leads_on %0b",
               $time, what, due.bpm, due.leads_on, bpm, on);
    fault_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rate_word_t due;
    ecg_word_t  w;
    if (!rst_ni) begin
      threshold   = 12'd2500;
      margin      = 12'd200;
      shortest_ms = 16'd300;
      longest_ms  = 16'd2000;
      armed       = 1'b0;
      last_beat   = '0;
      rate_now    = '0;
      slot        = 0;
      filled      = 0;
      fault_count = 0;
      rate_words_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_BEAT_THRESHOLD:  threshold   = cfg_i.data[THR_W-1:0];
          CFG_REARM_MARGIN:    margin      = cfg_i.data[THR_W-1:0];
          CFG_MIN_INTERVAL_MS: shortest_ms = cfg_i.data[INTERVAL_W-1:0];
          CFG_MAX_INTERVAL_MS: longest_ms  = cfg_i.data[INTERVAL_W-1:0];
          default: ;
        endcase
      end
      // results before new words, so a stray result is never matched early
      if (rate_i.valid && rate_i.ready) begin
        if (rate_words_due.size() == 0) begin
          note_fault("rate word with nothing due", '0, rate_i.bpm, rate_i.leads_on);
        end else begin
          due = rate_words_due.pop_front();
          if (rate_i.bpm !== due.bpm || rate_i.leads_on !== due.leads_on)
            note_fault("rate word mismatch", due, rate_i.bpm, rate_i.leads_on);
        end
      end
      if (word_i.valid && word_i.ready) begin
        w.sample         = word_i.sample;
        w.now_ms         = word_i.now_ms;
        w.lead_off_plus  = word_i.lead_off_plus;
        w.lead_off_minus = word_i.lead_off_minus;
        rate_words_due.push_back(beat_rate_step(w));
      end
      fail_count_o <= fault_count;
      pending_o    <= rate_words_due.size();
    end
  end

endmodule

@@ tb/heart_rate_from_peaks_test.sv @@
// testbench top: drives ECG words and register writes, gives the verdict
`timescale 1ns / 100ps

module heart_rate_from_peaks_test import hrp_pkg::*;;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 60;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd4;

  logic clk = 1'b0;
  logic rst_n;

  hrp_cfg_if                                 cfg_w ();
  hrp_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_w ();
  hrp_out_if                                 out_w ();

  int unsigned fail_count;
  int unsigned pending;

  heart_rate_from_peaks i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_w),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  heart_rate_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_i        (cfg_w),
    .word_i       (in_w),
    .rate_i       (out_w),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // settings as last written, for shaping the stimulus
  logic [THR_W-1:0]      thr_set    = 12'd2500;
  logic [THR_W-1:0]      margin_set = 12'd200;
  logic [INTERVAL_W-1:0] min_set    = 16'd300;
  logic [INTERVAL_W-1:0] max_set    = 16'd2000;

  int unsigned       words_sent = 0;
  bit                sender_calm = 1'b0;
  logic [TIME_W-1:0] stamp = '0;
  logic [TIME_W-1:0] prev_peak = '0;

  task automatic offer_word(input logic [SAMPLE_BITS_DEF-1:0] s, input logic [TIME_W-1:0] t,
                            input logic lop, input logic lom);
    int unsigned gap;
    if (words_sent % 48 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_w.valid          <= 1'b1;
    in_w.sample         <= s;
    in_w.now_ms         <= t;
    in_w.lead_off_plus  <= lop;
    in_w.lead_off_minus <= lom;
    do @(posedge clk); while (!(in_w.valid && in_w.ready));
    words_sent++;
  endtask

  // sender stops until every rate word is back and the block has gone quiet
  task automatic wait_idle();
    in_w.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_w.valid <= 1'b1;
    cfg_w.index <= idx;
    cfg_w.data  <= value;
    do @(posedge clk); while (!(cfg_w.valid && cfg_w.ready));
    cfg_w.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [THR_W-1:0] thr, input logic [THR_W-1:0] mrg,
                                input logic [INTERVAL_W-1:0] lo,
                                input logic [INTERVAL_W-1:0] hi);
    wait_idle();
    write_reg(CFG_BEAT_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_REARM_MARGIN, CFG_DATA_W'(mrg));
    write_reg(CFG_MIN_INTERVAL_MS, lo);
    write_reg(CFG_MAX_INTERVAL_MS, hi);
    thr_set    = thr;
    margin_set = mrg;
    min_set    = lo;
    max_set    = hi;
  endtask

  // mostly inside the accepted window, with its edges and some misses
  function automatic logic [TIME_W-1:0] pick_interval();
    int unsigned       pick;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    pick = $urandom_range(0, 19);
    lo   = min_set;
    hi   = max_set;
    case (pick)
      0: return lo;
      1: return hi;
      2: return lo - 1;
      3: return hi + 1;
      4: return $urandom_range(0, 199);
      5: return $urandom;
      default: ;
    endcase
    if (lo <= hi) begin
      // wide window: keep most intervals short so the rates vary
      if (hi - lo > 2000 && pick < 14) return $urandom_range(lo, lo + 2000);
      return $urandom_range(lo, hi);
    end
    return $urandom_range(200, 3000);
  endfunction

  // one beat: fall below re-arm (or lead off), maybe hover, peak if any level can cross, maybe linger
  task automatic run_beat();
    logic [TIME_W-1:0] peak_t;
    int unsigned       rearm_lvl;
    int unsigned       hover_lo;
    rearm_lvl = (margin_set <= thr_set) ? int'(thr_set) - int'(margin_set) : 0;
    hover_lo  = rearm_lvl;
    case ($urandom_range(0, 39))
      0: prev_peak = 32'hFFFF_FFFF - $urandom_range(0, 2500);
      1: prev_peak = $urandom;
      default: ;
    endcase
    if (rearm_lvl > 0) begin
      repeat ($urandom_range(1, 3)) begin
        stamp += $urandom_range(1, 40);
        offer_word($urandom_range(0, rearm_lvl - 1), stamp, 1'b0, 1'b0);
      end
    end else begin
      // no level can re-arm here, only a lead-off word clears the detector
      stamp += 1;
      offer_word($urandom, stamp, 1'b1, 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 3) == 0) begin
      stamp += $urandom_range(1, 40);
      offer_word($urandom_range(hover_lo, thr_set), stamp, 1'b0, 1'b0);
    end
    if (thr_set != '1) begin
      peak_t = prev_peak + pick_interval();
      if ($urandom_range(0, 39) == 0) peak_t = '0;
      offer_word($urandom_range(int'(thr_set) + 1, 4095), peak_t, 1'b0, 1'b0);
      prev_peak = peak_t;
      stamp     = peak_t;
    end
    repeat ($urandom_range(0, 2)) begin
      stamp += $urandom_range(1, 20);
      offer_word($urandom_range(hover_lo, 4095), stamp, 1'b0, 1'b0);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    logic [1:0]  flags;
    goal = words_sent + count;
    while (words_sent < goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        run_beat();
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 3)) begin
          flags = $urandom_range(1, 3);
          stamp += $urandom_range(0, 100);
          offer_word($urandom, stamp, flags[1], flags[0]);
        end
      end else begin
        // unshaped words, time jumps anywhere
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) stamp = $urandom;
          else stamp += $urandom_range(0, 500);
          offer_word($urandom, stamp, 1'b0, 1'b0);
        end
      end
    end
  endtask

  // receiver: random gaps, calm stretches, two long hold-offs
  initial begin : rate_sink
    int unsigned taken;
    int unsigned gap;
    bit          calm;
    taken = 0;
    calm  = 1'b0;
    out_w.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 150 || taken == 600) begin
        // queue fills and the block stalls its input meanwhile
        out_w.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_w.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_w.ready <= 1'b1;
      do @(posedge clk); while (!(out_w.valid && out_w.ready));
      taken++;
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [INTERVAL_W-1:0] lo;
    logic [THR_W-1:0]      thr;
    rst_n               <= 1'b0;
    in_w.valid          <= 1'b0;
    in_w.sample         <= '0;
    in_w.now_ms         <= '0;
    in_w.lead_off_plus  <= 1'b0;
    in_w.lead_off_minus <= 1'b0;
    cfg_w.valid         <= 1'b0;
    cfg_w.index         <= '0;
    cfg_w.data          <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset settings: re-arm below 2300
    offer_word(12'd0,    32'd100,  1'b0, 1'b0);  // floor, no beat yet
    offer_word(12'd4095, 32'd1000, 1'b0, 1'b0);  // first beat, nothing to measure
    offer_word(12'd2300, 32'd1005, 1'b0, 1'b0);  // at re-arm level: stays armed
    offer_word(12'd2501, 32'd1010, 1'b0, 1'b0);  // armed, no beat
    offer_word(12'd2299, 32'd1020, 1'b0, 1'b0);  // re-arm
    offer_word(12'd2501, 32'd1800, 1'b0, 1'b0);  // 800 ms
    offer_word(12'd2500, 32'd1810, 1'b0, 1'b0);  // at threshold, no crossing
    offer_word(12'd0,    32'd1820, 1'b0, 1'b0);
    offer_word(12'd2600, 32'd2100, 1'b0, 1'b0);  // shortest accepted
    offer_word(12'd0,    32'd2110, 1'b0, 1'b0);
    offer_word(12'd2600, 32'd4100, 1'b0, 1'b0);  // longest accepted
    offer_word(12'd0,    32'd4110, 1'b0, 1'b0);
    offer_word(12'd2600, 32'd4399, 1'b0, 1'b0);  // one short of the window
    offer_word(12'd0,    32'd4410, 1'b0, 1'b0);
    offer_word(12'd2600, 32'd6400, 1'b0, 1'b0);  // one past the window
    offer_word(12'd4095, 32'd6410, 1'b1, 1'b0);  // plus lead off
    offer_word(12'd4095, 32'd6420, 1'b0, 1'b1);  // minus lead off
    offer_word(12'd0,    32'd6430, 1'b1, 1'b1);  // both off
    offer_word(12'd3000, 32'd7000, 1'b0, 1'b0);  // disarmed by lead-off: beat
    offer_word(12'd0,    32'd7010, 1'b0, 1'b0);
    offer_word(12'd3000, 32'd0,    1'b0, 1'b0);  // beat at time zero
    offer_word(12'd0,    32'd10,   1'b0, 1'b0);
    offer_word(12'd3000, 32'd500,  1'b0, 1'b0);  // zero read as no previous beat
    offer_word(12'd0,    32'd510,  1'b0, 1'b0);
    offer_word(12'd3000, 32'hFFFF_FF00, 1'b0, 1'b0);
    offer_word(12'd0,    32'hFFFF_FF10, 1'b0, 1'b0);
    offer_word(12'd3000, 32'h0000_01F0, 1'b0, 1'b0);  // interval across the wrap
    prev_peak = 32'h0000_01F0;
    stamp     = 32'h0000_01F0;

    run_random(250);

    // margin above threshold, widest window
    apply_settings(12'd2048, 12'd4095, 16'd200, 16'hFFFF);
    run_random(110);
    // lowest threshold and margin, saturating rates
    apply_settings(12'd0, 12'd0, 16'd200, 16'd400);
    run_random(110);
    // nothing can cross the top threshold
    apply_settings(12'd4095, 12'd0, 16'hFFFF, 16'hFFFF);
    run_random(30);

    thr = $urandom_range(500, 3500);
    lo  = $urandom_range(200, 800);
    apply_settings(thr, $urandom_range(0, thr / 2), lo, $urandom_range(lo, 3000));
    run_random(200);

    // empty window: every interval rejected
    thr = $urandom_range(500, 3500);
    lo  = $urandom_range(1000, 3000);
    apply_settings(thr, $urandom_range(0, thr / 2), lo, $urandom_range(200, lo - 1));
    write_reg(CFG_UNUSED_IDX, $urandom);
    run_random(80);

    apply_settings(12'd2500, 12'd200, 16'd300, 16'd2000);
    run_random(120);

    wait_idle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ heart_rate_from_peaks.f @@
+incdir+hw/rtl
hw/rtl/hrp_pkg.sv
hw/rtl/hrp_if.sv
hw/rtl/hrp_div.sv
hw/rtl/hrp_fifo.sv
hw/rtl/hrp_front.sv
hw/rtl/hrp_back.sv
hw/rtl/heart_rate_from_peaks.sv
tb/heart_rate_checker.sv
tb/heart_rate_from_peaks_test.sv
